// ----- design/mfe_pkg.sv -----
// ----------------------------------------------------------------------------
// mfe_pkg: shared types for the multi-pipe byte FIFO engine
// Command and status codes, the transfer payloads of both channels and the
// control groups passed between the pipe table and the top level.
// ----------------------------------------------------------------------------
package mfe_pkg;

  // Command codes carried in the command field
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_CLOSE  = 2'd3
  } mfe_cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_WOULD_BLOCK    = 3'd1,
    ST_END_OF_STREAM  = 3'd2,
    ST_BROKEN_PIPE    = 3'd3,
    ST_BAD_DESCRIPTOR = 3'd4,
    ST_NO_FREE_PIPE   = 3'd5,
    ST_EXHAUSTED      = 3'd6
  } mfe_status_t;

  // Descriptor counter: first handed out value and last value a create may use
  localparam logic [15:0] FIRST_DESCRIPTOR    = 16'd32;
  localparam logic [15:0] LAST_CREATE_COUNTER = 16'd65532;
  localparam logic [15:0] COUNT_MAX           = 16'hFFFF;

  // Input transfer
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] descriptor;
    logic [7:0]  write_data;
    logic        final_req;
  } mfe_in_t;

  // Result transfer
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [15:0] new_descriptor;
    logic [15:0] transfer_count;
    logic        transfer_done;
  } mfe_out_t;

  // Byte store access strobes
  typedef struct packed {
    logic we;
    logic re;
  } mfe_memctl_t;

  // Result of the table stage, waiting for the byte store read data
  typedef struct packed {
    mfe_status_t status;
    logic [15:0] new_descriptor;
    logic [15:0] transfer_count;
    logic        transfer_done;
    logic        take_byte;
  } mfe_pend_t;

endpackage

// ----- design/mfe_byte_store.sv -----
// ----------------------------------------------------------------------------
// mfe_byte_store: ring buffer storage for all pipes
// Single-port synchronous RAM, one write or one read per cycle, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module mfe_byte_store #(
  parameter int ADDR_W = 12,
  parameter int DEPTH  = 4096
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write the byte at the head of a pipe
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read the byte at the tail of a pipe, hold until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mfe_slot_table.sv -----
// ----------------------------------------------------------------------------
// mfe_slot_table: pipe table, descriptor lookup and command decision
// Holds per-pipe state, matches the descriptor against all pipes in
// parallel, decides the outcome of a command and drives the byte store.
// ----------------------------------------------------------------------------
module mfe_slot_table #(
  parameter int NUM_PIPES  = 8,
  parameter int PIPE_DEPTH = 512,
  localparam int SLOT_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1,
  localparam int PTR_W     = $clog2(PIPE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_acc,
  input  mfe_pkg::mfe_in_t          req,
  output mfe_pkg::mfe_memctl_t      mem_ctl,
  output logic [SLOT_W+PTR_W-1:0]   mem_addr,
  output mfe_pkg::mfe_pend_t        pend
);

  import mfe_pkg::*;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(PIPE_DEPTH - 1);

  // Per-pipe state
  logic [NUM_PIPES-1:0] in_use_r, in_use_nxt;
  logic [NUM_PIPES-1:0] rd_open_r, rd_open_nxt;
  logic [NUM_PIPES-1:0] wr_open_r, wr_open_nxt;
  logic [15:0]          rdesc_r [NUM_PIPES];
  logic [15:0]          rdesc_nxt [NUM_PIPES];
  logic [PTR_W-1:0]     head_r [NUM_PIPES];
  logic [PTR_W-1:0]     head_nxt [NUM_PIPES];
  logic [PTR_W-1:0]     tail_r [NUM_PIPES];
  logic [PTR_W-1:0]     tail_nxt [NUM_PIPES];
  logic [15:0]          next_desc_r, next_desc_nxt;
  logic [15:0]          count_r, count_nxt;

  logic [NUM_PIPES-1:0] hit_rd, hit_wr, match;
  logic [SLOT_W-1:0]    sel, free_sel;
  logic                 found, any_free;
  logic [PTR_W-1:0]     head_s, tail_s, head_inc;
  logic [15:0]          rdesc_s, count_inc;
  logic                 close_rd, close_wr, rd_left, wr_left;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  // Match the descriptor against every pipe in use
  always_comb begin
    for (int i = 0; i < NUM_PIPES; i++) begin
      hit_rd[i] = in_use_r[i] && (rdesc_r[i] == req.descriptor);
      hit_wr[i] = in_use_r[i] && ((rdesc_r[i] + 16'd1) == req.descriptor);
    end
    unique case (req.command)
      CMD_READ:  match = hit_rd;
      CMD_WRITE: match = hit_wr;
      default:   match = hit_rd | hit_wr;
    endcase
  end

  // Pick the lowest matching pipe and the lowest free pipe
  always_comb begin
    sel      = '0;
    free_sel = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel = SLOT_W'(i);
      end
      if (!in_use_r[i]) begin
        free_sel = SLOT_W'(i);
      end
    end
    found    = |match;
    any_free = ~&in_use_r;
  end

  assign head_s    = head_r[sel];
  assign tail_s    = tail_r[sel];
  assign rdesc_s   = rdesc_r[sel];
  assign head_inc  = ptr_inc(head_s);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
  assign close_rd  = (rdesc_s == req.descriptor);
  assign close_wr  = ((rdesc_s + 16'd1) == req.descriptor);
  assign rd_left   = rd_open_r[sel] && !close_rd;
  assign wr_left   = wr_open_r[sel] && !close_wr;

  // Decide the command outcome and the next table state
  always_comb begin
    in_use_nxt    = in_use_r;
    rd_open_nxt   = rd_open_r;
    wr_open_nxt   = wr_open_r;
    rdesc_nxt     = rdesc_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    next_desc_nxt = next_desc_r;
    count_nxt     = count_r;
    pend          = '0;
    pend.status   = ST_OK;
    mem_ctl       = '0;
    mem_addr      = {sel, tail_s};

    unique case (req.command)
      CMD_CREATE: begin
        if (!any_free) begin
          pend.status = ST_NO_FREE_PIPE;
        end else if (next_desc_r > LAST_CREATE_COUNTER) begin
          pend.status = ST_EXHAUSTED;
        end else begin
          in_use_nxt[free_sel]  = 1'b1;
          rd_open_nxt[free_sel] = 1'b1;
          wr_open_nxt[free_sel] = 1'b1;
          rdesc_nxt[free_sel]   = next_desc_r;
          head_nxt[free_sel]    = '0;
          tail_nxt[free_sel]    = '0;
          pend.new_descriptor   = next_desc_r;
          next_desc_nxt         = next_desc_r + 16'd2;
        end
      end
      CMD_READ: begin
        if (!found) begin
          pend.status        = ST_BAD_DESCRIPTOR;
          pend.transfer_done = 1'b1;
          count_nxt          = '0;
        end else if (head_s != tail_s) begin
          mem_ctl.re          = req_acc;
          tail_nxt[sel]       = ptr_inc(tail_s);
          pend.take_byte      = 1'b1;
          pend.transfer_count = count_inc;
          pend.transfer_done  = req.final_req;
          count_nxt           = req.final_req ? 16'd0 : count_inc;
        end else if (!wr_open_r[sel]) begin
          pend.status         = ST_END_OF_STREAM;
          pend.transfer_count = count_r;
          pend.transfer_done  = 1'b1;
          count_nxt           = '0;
        end else begin
          pend.status         = ST_WOULD_BLOCK;
          pend.transfer_count = count_r;
        end
      end
      CMD_WRITE: begin
        mem_addr = {sel, head_s};
        if (!found) begin
          pend.status        = ST_BAD_DESCRIPTOR;
          pend.transfer_done = 1'b1;
          count_nxt          = '0;
        end else if (head_inc != tail_s) begin
          mem_ctl.we          = req_acc;
          head_nxt[sel]       = head_inc;
          pend.transfer_count = count_inc;
          pend.transfer_done  = req.final_req;
          count_nxt           = req.final_req ? 16'd0 : count_inc;
        end else if (!rd_open_r[sel]) begin
          pend.status         = ST_BROKEN_PIPE;
          pend.transfer_count = count_r;
          pend.transfer_done  = 1'b1;
          count_nxt           = '0;
        end else begin
          pend.status         = ST_WOULD_BLOCK;
          pend.transfer_count = count_r;
        end
      end
      CMD_CLOSE: begin
        if (!found) begin
          pend.status = ST_BAD_DESCRIPTOR;
        end else begin
          rd_open_nxt[sel] = rd_left;
          wr_open_nxt[sel] = wr_left;
          if (!rd_left && !wr_left) begin
            in_use_nxt[sel] = 1'b0;
          end
        end
      end
    endcase
  end

  // Advance control state on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      rd_open_r   <= '0;
      wr_open_r   <= '0;
      next_desc_r <= FIRST_DESCRIPTOR;
      count_r     <= '0;
    end else if (req_acc) begin
      in_use_r    <= in_use_nxt;
      rd_open_r   <= rd_open_nxt;
      wr_open_r   <= wr_open_nxt;
      next_desc_r <= next_desc_nxt;
      count_r     <= count_nxt;
    end
  end

  // Update per-pipe descriptors and ring pointers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      rdesc_r <= rdesc_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  // Checks
  a_desc_even: assert property (@(posedge clk) disable iff (!rst_n)
    next_desc_r[0] == 1'b0)
    else $error("descriptor counter lost its even alignment");

  a_open_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    ((rd_open_r | wr_open_r) & ~in_use_r) == '0)
    else $error("open end on a free pipe");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.we && mem_ctl.re))
    else $error("byte store read and write in the same cycle");

  a_access_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.we || mem_ctl.re) |-> req_acc)
    else $error("byte store access without an accepted transfer");

endmodule

// ----- design/multi_pipe_byte_fifo_engine.sv -----
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_engine: table of byte pipes with blocking status
// Create, read, write and close on ring-buffer pipes held in one byte store.
//
//   Channel   Ports                    Direction  Content
//   input     in_valid/in_ready/in_data  in       command, descriptor, byte
//   result    out_valid/out_ready/out_data out    status, byte, counts
//
// One transfer a cycle while the result channel does not stall: the pipe
// table decides and updates in the accept cycle, the byte store registers
// its read data as p1_r takes the decision, then the result is registered.
// Rate is set by the single port of the byte store, one access per item.
// Reset is synchronous; no clearing pass, the byte store is never read
// before written. A stalled result holds one further item in the table stage.
// ----------------------------------------------------------------------------
module multi_pipe_byte_fifo_engine #(
  parameter int NUM_PIPES  = 8,
  parameter int PIPE_DEPTH = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfe_pkg::mfe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfe_pkg::mfe_out_t out_data
);

  import mfe_pkg::*;

  localparam int SLOT_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PTR_W     = $clog2(PIPE_DEPTH);
  localparam int ADDR_W    = SLOT_W + PTR_W;
  localparam int MEM_DEPTH = NUM_PIPES * (2 ** PTR_W);

  logic                 in_acc;
  logic                 p1_move;
  logic                 p1_valid_r;
  mfe_pend_t            p1_r;
  mfe_pend_t            pend;
  mfe_memctl_t          mem_ctl;
  logic [ADDR_W-1:0]    mem_addr;
  logic [7:0]           mem_rdata;
  logic                 out_valid_r;
  mfe_out_t             out_data_r;

  mfe_slot_table #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_DEPTH (PIPE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_acc  (in_acc),
    .req      (in_data),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr),
    .pend     (pend)
  );

  mfe_byte_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_ctl.we),
    .re    (mem_ctl.re),
    .addr  (mem_addr),
    .wdata (in_data.write_data),
    .rdata (mem_rdata)
  );

  // Handshake: the table stage frees when its result moves to the output
  assign p1_move  = p1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p1_valid_r || p1_move;
  assign in_acc   = in_valid && in_ready;

  // Hold the table decision until the read data arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_acc) begin
      p1_valid_r <= 1'b1;
    end else if (p1_move) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_r <= pend;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_data_r.status         <= p1_r.status;
      out_data_r.read_data      <= p1_r.take_byte ? mem_rdata : 8'd0;
      out_data_r.new_descriptor <= p1_r.new_descriptor;
      out_data_r.transfer_count <= p1_r.transfer_count;
      out_data_r.transfer_done  <= p1_r.transfer_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    p1_move |=> out_valid_r)
    else $error("table result dropped on its way to the output");

  a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.read_data == 8'd0))
    else $error("read byte returned on a failed item");

  a_block_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_WOULD_BLOCK)) |-> !out_data_r.transfer_done)
    else $error("blocked item ended the call");

endmodule
